// ===== sv/sdfp_pkg.sv =====
// shared types and constants of the signed distance field pixel core
// no dependencies; used by signed_distance_field_pixel_core
package sdfp_pkg;

  // input word: a segment load or a pixel evaluation
  typedef struct packed {
    logic               kind;
    logic               restart;
    logic signed [23:0] seg_start_x;
    logic signed [23:0] seg_start_y;
    logic signed [23:0] seg_end_x;
    logic signed [23:0] seg_end_y;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
  } sdfp_in_t;

  // result word
  typedef struct packed {
    logic [7:0] sdf_value;
    logic       inside_res;
  } sdfp_out_t;

  // input word kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_SCALE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_GAIN = 8'd3;

  // register reset values
  localparam logic [31:0] INVERSE_SCALE_RESET = 32'd65536;
  localparam logic [23:0] DISTANCE_GAIN_RESET = 24'd262144;

endpackage

// ===== sv/signed_distance_field_pixel_core.sv =====
// signed distance field pixel core: segment store, distance/crossing pipeline, output encode
// depends on sdfp_pkg
// segment load: taken whenever idle, busy stays low, so loads can follow back to back
// pixel with N stored segments: a mapping step, a scan of the N segments, a drain, 31 root
// steps, a gain and an encode step; result_valid rises when the encode step ends
// and busy drops in that same cycle, so a new pixel is taken only after the last result
// empty store pixel: result in the cycle after start. results cannot be stalled by the receiver.
// reset (synchronous) empties the store and loads the register defaults; no clearing pass.
module signed_distance_field_pixel_core #(
  parameter int MAX_SEGMENTS     = 2048,
  parameter int FRACTION_BITS    = 8,
  parameter int PIXEL_COORD_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  sdfp_pkg::sdfp_in_t                  item,
  output logic                                result_valid,
  output sdfp_pkg::sdfp_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sdfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W      = $clog2(MAX_SEGMENTS);
  localparam int CNT_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int ROUND_SHIFT = FRACTION_BITS + 20;
  localparam int DIV_STEPS   = 16;
  localparam int ROOT_STEPS  = 31;
  localparam logic [7:0] PIX_MASK = 8'((16'd1 << PIXEL_COORD_BITS) - 16'd1);

  localparam logic signed [58:0] COORD_MAX = 59'sd16777215;
  localparam logic signed [58:0] COORD_MIN = -59'sd16777216;

  // nearest point selection
  localparam logic [1:0] SEL_START  = 2'd0;
  localparam logic [1:0] SEL_END    = 2'd1;
  localparam logic [1:0] SEL_INTERP = 2'd2;

  // controller states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_GAIN  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // pixel to font units, rounded and saturated
  function automatic logic signed [24:0] map_coord(input logic [7:0] pix,
                                                   input logic signed [23:0] off,
                                                   input logic [31:0] scale);
    logic [25:0]        pix_sh;
    logic signed [25:0] f;
    logic signed [58:0] prod;
    logic signed [58:0] rnd;
    pix_sh = 26'(pix & PIX_MASK) << FRACTION_BITS;
    f      = $signed(pix_sh) - 26'(off);
    prod   = f * $signed({1'b0, scale});
    rnd    = (prod + 59'sd32768) >>> 16;
    if (rnd < COORD_MIN) begin
      rnd = COORD_MIN;
    end else if (rnd > COORD_MAX) begin
      rnd = COORD_MAX;
    end
    map_coord = rnd[24:0];
  endfunction

  logic [2:0] state;

  // configuration registers
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [31:0]        inverse_scale;
  logic [23:0]        distance_gain;

  logic [CNT_W-1:0] seg_total;
  logic [CNT_W-1:0] load_base;
  logic             in_take;

  logic [7:0] pix_x;
  logic [7:0] pix_y;
  logic signed [24:0] px_r;
  logic signed [24:0] py_r;

  // segment memories: start point and end point, {x, y}
  logic [47:0] mem_a [MAX_SEGMENTS];
  logic [47:0] mem_b [MAX_SEGMENTS];
  logic [47:0] mem_a_q;
  logic [47:0] mem_b_q;
  logic        vld_m;
  logic [CNT_W-1:0] idx;
  logic        issue;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;
  assign load_base = item.restart ? '0 : seg_total;
  assign issue     = (state == ST_SCAN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inverse_scale <= sdfp_pkg::INVERSE_SCALE_RESET;
      distance_gain <= sdfp_pkg::DISTANCE_GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdfp_pkg::CFG_ORIGIN_X:      origin_x      <= cfg_data[23:0];
        sdfp_pkg::CFG_ORIGIN_Y:      origin_y      <= cfg_data[23:0];
        sdfp_pkg::CFG_INVERSE_SCALE: inverse_scale <= cfg_data;
        sdfp_pkg::CFG_DISTANCE_GAIN: distance_gain <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // segment store write and read port
  always_ff @(posedge clk) begin
    if (in_take && item.kind == sdfp_pkg::KIND_SEGMENT &&
        load_base < CNT_W'(MAX_SEGMENTS)) begin
      mem_a[load_base[ADDR_W-1:0]] <= {item.seg_start_x, item.seg_start_y};
      mem_b[load_base[ADDR_W-1:0]] <= {item.seg_end_x, item.seg_end_y};
    end
    mem_a_q <= mem_a[idx[ADDR_W-1:0]];
    mem_b_q <= mem_b[idx[ADDR_W-1:0]];
  end

  // stage 1: differences and straddle test
  logic signed [23:0] ax_m, ay_m, bx_m, by_m;
  logic signed [24:0] abx_c, aby_c;
  logic signed [25:0] apx_c, apy_c;
  logic               strad_c;

  always_comb begin
    ax_m  = mem_a_q[47:24];
    ay_m  = mem_a_q[23:0];
    bx_m  = mem_b_q[47:24];
    by_m  = mem_b_q[23:0];
    abx_c = 25'(bx_m) - 25'(ax_m);
    aby_c = 25'(by_m) - 25'(ay_m);
    apx_c = 26'(px_r) - 26'(ax_m);
    apy_c = 26'(py_r) - 26'(ay_m);
    strad_c = (25'(ay_m) <= py_r && 25'(by_m) > py_r) ||
              (25'(by_m) <= py_r && 25'(ay_m) > py_r);
  end

  logic               v_s1;
  logic signed [23:0] s1_ax, s1_ay;
  logic signed [24:0] s1_abx, s1_aby;
  logic signed [25:0] s1_apx, s1_apy;
  logic               s1_strad;

  // stage 2: products
  logic               v_s2;
  logic signed [23:0] s2_ax, s2_ay;
  logic signed [24:0] s2_abx, s2_aby;
  logic signed [49:0] s2_lxx, s2_lyy;
  logic signed [50:0] s2_dpx, s2_dpy, s2_ca, s2_cb;
  logic               s2_strad;

  // stage 3: sums and nearest point choice
  logic signed [50:0] len2_c;
  logic signed [51:0] dot_c;
  logic signed [51:0] num_c;
  logic [1:0]         sel_c;
  logic               cross_c;

  always_comb begin
    len2_c = 51'(s2_lxx) + 51'(s2_lyy);
    dot_c  = 52'(s2_dpx) + 52'(s2_dpy);
    num_c  = 52'(s2_cb) - 52'(s2_ca);
    if (len2_c == 51'sd0 || dot_c <= 52'sd0) begin
      sel_c = SEL_START;
    end else if (dot_c >= 52'(len2_c)) begin
      sel_c = SEL_END;
    end else begin
      sel_c = SEL_INTERP;
    end
    cross_c = s2_strad && ((s2_aby > 25'sd0) ? (num_c > 52'sd0) : (num_c < 52'sd0));
  end

  // divider pipeline, one quotient bit per stage
  logic               dv_v     [DIV_STEPS+1];
  logic [51:0]        dv_rem   [DIV_STEPS+1];
  logic [51:0]        dv_len   [DIV_STEPS+1];
  logic [15:0]        dv_t     [DIV_STEPS+1];
  logic signed [23:0] dv_ax    [DIV_STEPS+1];
  logic signed [23:0] dv_ay    [DIV_STEPS+1];
  logic signed [24:0] dv_abx   [DIV_STEPS+1];
  logic signed [24:0] dv_aby   [DIV_STEPS+1];
  logic [1:0]         dv_sel   [DIV_STEPS+1];
  logic               dv_cross [DIV_STEPS+1];
  logic [51:0]        dv_rem_next [DIV_STEPS];
  logic [15:0]        dv_t_next   [DIV_STEPS];
  logic [51:0]        dv_shift    [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_shift[k] = {dv_rem[k][50:0], 1'b0};
      if (dv_shift[k] >= dv_len[k]) begin
        dv_rem_next[k] = dv_shift[k] - dv_len[k];
        dv_t_next[k]   = {dv_t[k][14:0], 1'b1};
      end else begin
        dv_rem_next[k] = dv_shift[k];
        dv_t_next[k]   = {dv_t[k][14:0], 1'b0};
      end
    end
  end

  // stage t: quotient times segment vector
  logic               v_st;
  logic signed [41:0] st_prx, st_pry;
  logic signed [23:0] st_ax, st_ay;
  logic signed [24:0] st_abx, st_aby;
  logic [1:0]         st_sel;
  logic               st_cross;

  // stage c: nearest point and offset
  logic signed [25:0] rx_c, ry_c;
  logic signed [26:0] cx_c, cy_c;

  always_comb begin
    rx_c = 26'((st_prx + 42'sd32768) >>> 16);
    ry_c = 26'((st_pry + 42'sd32768) >>> 16);
    case (st_sel)
      SEL_END: begin
        cx_c = 27'(st_ax) + 27'(st_abx);
        cy_c = 27'(st_ay) + 27'(st_aby);
      end
      SEL_INTERP: begin
        cx_c = 27'(st_ax) + 27'(rx_c);
        cy_c = 27'(st_ay) + 27'(ry_c);
      end
      default: begin
        cx_c = 27'(st_ax);
        cy_c = 27'(st_ay);
      end
    endcase
  end

  logic               v_sc;
  logic signed [27:0] sc_dx, sc_dy;
  logic               sc_cross;

  // stage q: squares
  logic               v_sq;
  logic signed [55:0] sq_x, sq_y;
  logic               sq_cross;

  logic [53:0] d2_c;
  logic [53:0] best;
  logic        first;
  logic        parity;

  assign d2_c = 54'(sq_x[52:0]) + 54'(sq_y[52:0]);

  logic pipe_busy;
  always_comb begin
    pipe_busy = vld_m || v_s1 || v_s2 || v_st || v_sc || v_sq;
    for (int k = 0; k <= DIV_STEPS; k++) begin
      pipe_busy = pipe_busy || dv_v[k];
    end
  end

  // pipeline data path
  always_ff @(posedge clk) begin
    s1_ax    <= ax_m;
    s1_ay    <= ay_m;
    s1_abx   <= abx_c;
    s1_aby   <= aby_c;
    s1_apx   <= apx_c;
    s1_apy   <= apy_c;
    s1_strad <= strad_c;

    s2_ax    <= s1_ax;
    s2_ay    <= s1_ay;
    s2_abx   <= s1_abx;
    s2_aby   <= s1_aby;
    s2_lxx   <= s1_abx * s1_abx;
    s2_lyy   <= s1_aby * s1_aby;
    s2_dpx   <= s1_apx * s1_abx;
    s2_dpy   <= s1_apy * s1_aby;
    s2_ca    <= s1_apx * s1_aby;
    s2_cb    <= s1_apy * s1_abx;
    s2_strad <= s1_strad;

    dv_rem[0]   <= dot_c[51:0];
    dv_len[0]   <= {1'b0, len2_c[50:0]};
    dv_t[0]     <= '0;
    dv_ax[0]    <= s2_ax;
    dv_ay[0]    <= s2_ay;
    dv_abx[0]   <= s2_abx;
    dv_aby[0]   <= s2_aby;
    dv_sel[0]   <= sel_c;
    dv_cross[0] <= cross_c;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_rem[k+1]   <= dv_rem_next[k];
      dv_len[k+1]   <= dv_len[k];
      dv_t[k+1]     <= dv_t_next[k];
      dv_ax[k+1]    <= dv_ax[k];
      dv_ay[k+1]    <= dv_ay[k];
      dv_abx[k+1]   <= dv_abx[k];
      dv_aby[k+1]   <= dv_aby[k];
      dv_sel[k+1]   <= dv_sel[k];
      dv_cross[k+1] <= dv_cross[k];
    end

    st_prx   <= $signed({1'b0, dv_t[DIV_STEPS]}) * dv_abx[DIV_STEPS];
    st_pry   <= $signed({1'b0, dv_t[DIV_STEPS]}) * dv_aby[DIV_STEPS];
    st_ax    <= dv_ax[DIV_STEPS];
    st_ay    <= dv_ay[DIV_STEPS];
    st_abx   <= dv_abx[DIV_STEPS];
    st_aby   <= dv_aby[DIV_STEPS];
    st_sel   <= dv_sel[DIV_STEPS];
    st_cross <= dv_cross[DIV_STEPS];

    sc_dx    <= 28'(px_r) - 28'(cx_c);
    sc_dy    <= 28'(py_r) - 28'(cy_c);
    sc_cross <= st_cross;

    sq_x     <= sc_dx * sc_dx;
    sq_y     <= sc_dy * sc_dy;
    sq_cross <= sc_cross;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
      v_s1  <= 1'b0;
      v_s2  <= 1'b0;
      v_st  <= 1'b0;
      v_sc  <= 1'b0;
      v_sq  <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v[k] <= 1'b0;
      end
    end else begin
      vld_m   <= issue;
      v_s1    <= vld_m;
      v_s2    <= v_s1;
      dv_v[0] <= v_s2;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_v[k+1] <= dv_v[k];
      end
      v_st <= dv_v[DIV_STEPS];
      v_sc <= v_st;
      v_sq <= v_sc;
    end
  end

  // square root unit, one result bit per step
  logic [61:0] rt_rad, rt_res, rt_bit, rt_trial;
  logic [4:0]  rt_cnt;
  logic [54:0] q_r;

  assign rt_trial = rt_res + rt_bit;

  // output encode
  logic signed [63:0] s_v, v_sum, v_sh;
  logic [7:0]         sdf_c;

  always_comb begin
    s_v   = parity ? -$signed(64'(q_r)) : $signed(64'(q_r));
    v_sum = s_v + (64'sd128 <<< ROUND_SHIFT) + (64'sd1 <<< (ROUND_SHIFT - 1));
    v_sh  = v_sum >>> ROUND_SHIFT;
    if (v_sum < 64'sd0) begin
      sdf_c = 8'd0;
    end else if (v_sh > 64'sd255) begin
      sdf_c = 8'd255;
    end else begin
      sdf_c = v_sh[7:0];
    end
  end

  // controller, accumulator and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seg_total    <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
      first        <= 1'b0;
      parity       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (v_sq) begin
        if (first || d2_c < best) begin
          best <= d2_c;
        end
        first  <= 1'b0;
        parity <= parity ^ sq_cross;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (item.kind == sdfp_pkg::KIND_SEGMENT) begin
              if (load_base < CNT_W'(MAX_SEGMENTS)) begin
                seg_total <= load_base + CNT_W'(1);
              end else begin
                seg_total <= load_base;
              end
            end else if (seg_total == '0) begin
              result_valid <= 1'b1;
              result       <= '0;
            end else begin
              pix_x <= item.pixel_x;
              pix_y <= item.pixel_y;
              state <= ST_MAP;
            end
          end
        end
        ST_MAP: begin
          px_r   <= map_coord(pix_x, origin_x, inverse_scale);
          py_r   <= map_coord(pix_y, origin_y, inverse_scale);
          idx    <= '0;
          first  <= 1'b1;
          parity <= 1'b0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          idx <= idx + CNT_W'(1);
          if (idx == seg_total - CNT_W'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            rt_rad <= {best, 8'd0};
            rt_res <= '0;
            rt_bit <= 62'(1) << 60;
            rt_cnt <= 5'(ROOT_STEPS);
            state  <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rt_rad >= rt_trial) begin
            rt_rad <= rt_rad - rt_trial;
            rt_res <= (rt_res >> 1) + rt_bit;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_bit <= rt_bit >> 2;
          rt_cnt <= rt_cnt - 5'd1;
          if (rt_cnt == 5'd1) begin
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          q_r   <= rt_res[30:0] * distance_gain;
          state <= ST_OUT;
        end
        ST_OUT: begin
          result_valid      <= 1'b1;
          result.sdf_value  <= sdf_c;
          result.inside_res <= parity;
          state             <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
